// ===== hw/rtl/amo_pkg.sv =====
// Shared types and operation codes for the atomic memory operation unit.
package amo_pkg;

   localparam logic [4:0] OP_ADD  = 5'b00000;
   localparam logic [4:0] OP_SWAP = 5'b00001;
   localparam logic [4:0] OP_LR   = 5'b00010;
   localparam logic [4:0] OP_SC   = 5'b00011;
   localparam logic [4:0] OP_XOR  = 5'b00100;
   localparam logic [4:0] OP_OR   = 5'b01000;
   localparam logic [4:0] OP_AND  = 5'b01100;
   localparam logic [4:0] OP_MIN  = 5'b10000;
   localparam logic [4:0] OP_MAX  = 5'b10100;
   localparam logic [4:0] OP_MINU = 5'b11000;
   localparam logic [4:0] OP_MAXU = 5'b11100;

   localparam logic [2:0] WIDTH_DOUBLE = 3'b011;

   typedef struct packed {
      logic [4:0]  cmd;
      logic [2:0]  width_sel;
      logic [63:0] address;
      logic [63:0] operand_value;
      logic [63:0] memory_preimage;
      logic        access_ok;
   } req_type;

   typedef struct packed {
      logic        illegal;
      logic        mem_write;
      logic        mem_write_wide;
      logic [63:0] mem_write_data;
      logic        rd_write;
      logic [63:0] rd_value;
   } rsp_type;

   typedef struct packed {
      logic        set;
      logic        clear;
      logic [63:0] address;
   } resv_upd_type;

endpackage

// ===== hw/rtl/amo_alu.sv =====
// Combinational datapath: LR/SC reservation test and AMO combine for one request.
module amo_alu (
   input  amo_pkg::req_type      req,
   input  logic                  xlen_is_64,
   input  logic                  resv_valid,
   input  logic [63:0]           resv_address,
   output amo_pkg::rsp_type      rsp,
   output amo_pkg::resv_upd_type resv_upd
);

   logic        wide;
   logic [63:0] loaded;
   logic [63:0] opnd;
   logic [63:0] combined;
   logic [63:0] store_val;
   logic        sc_match;

   assign wide     = (req.width_sel == amo_pkg::WIDTH_DOUBLE);
   assign loaded   = wide ? req.memory_preimage
                          : {{32{req.memory_preimage[31]}}, req.memory_preimage[31:0]};
   assign opnd     = wide ? req.operand_value
                          : {{32{req.operand_value[31]}}, req.operand_value[31:0]};
   assign sc_match = resv_valid && (resv_address == req.address);

   always_comb begin
      case (req.cmd)
         amo_pkg::OP_SWAP: combined = opnd;
         amo_pkg::OP_ADD:  combined = loaded + opnd;
         amo_pkg::OP_XOR:  combined = loaded ^ opnd;
         amo_pkg::OP_AND:  combined = loaded & opnd;
         amo_pkg::OP_OR:   combined = loaded | opnd;
         amo_pkg::OP_MIN:  combined = ($signed(loaded) < $signed(opnd)) ? loaded : opnd;
         amo_pkg::OP_MAX:  combined = ($signed(opnd) < $signed(loaded)) ? loaded : opnd;
         amo_pkg::OP_MINU: combined = (loaded < opnd) ? loaded : opnd;
         amo_pkg::OP_MAXU: combined = (loaded > opnd) ? loaded : opnd;
         default:          combined = loaded;
      endcase
   end

   always_comb begin
      rsp              = '0;
      resv_upd.set     = 1'b0;
      resv_upd.clear   = 1'b0;
      resv_upd.address = req.address;
      store_val        = (req.cmd == amo_pkg::OP_SC) ? req.operand_value : combined;
      if (wide && !xlen_is_64) begin
         rsp.illegal = 1'b1;
      end else if (req.access_ok) begin
         rsp.rd_write = 1'b1;
         if (req.cmd == amo_pkg::OP_SC) begin
            resv_upd.clear = 1'b1;
            rsp.rd_value   = {63'd0, !sc_match};
            if (sc_match) begin
               rsp.mem_write      = 1'b1;
               rsp.mem_write_wide = wide;
               rsp.mem_write_data = wide ? store_val : {32'd0, store_val[31:0]};
            end
         end else begin
            rsp.rd_value = loaded;
            if (req.cmd == amo_pkg::OP_LR) begin
               resv_upd.set = 1'b1;
            end else begin
               rsp.mem_write      = 1'b1;
               rsp.mem_write_wide = wide;
               rsp.mem_write_data = wide ? store_val : {32'd0, store_val[31:0]};
            end
         end
      end
   end

endmodule

// ===== hw/rtl/atomic_memory_op_unit_core.sv =====
// Top level of the atomic memory operation unit: request register, datapath, response register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | cmd, width_sel, address, operand, preimage, ok
//  rsp     | out       | rsp_valid/rsp_ready  | illegal, mem write, rd write and value
//  csr     | in        | csr_write_enable     | xlen_is_64
//
// One request per cycle unless the response stalls; request register, then response register.
// The reservation is updated as a request moves into the response register.
// A stalled response holds; the request register still refills while the response drains.
// Synchronous active-high reset clears valids and the reservation and sets xlen_is_64.
module atomic_memory_op_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_cmd,
   input  logic [2:0]  req_width_sel,
   input  logic [63:0] req_address,
   input  logic [63:0] req_operand_value,
   input  logic [63:0] req_memory_preimage,
   input  logic        req_access_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_illegal,
   output logic        rsp_mem_write,
   output logic        rsp_mem_write_wide,
   output logic [63:0] rsp_mem_write_data,
   output logic        rsp_rd_write,
   output logic [63:0] rsp_rd_value
);

   amo_pkg::req_type      req_ff;
   amo_pkg::req_type      req_in;
   logic                  req_valid_ff;
   amo_pkg::rsp_type      rsp_ff;
   amo_pkg::rsp_type      rsp_in;
   logic                  rsp_valid_ff;
   logic                  xlen_ff;
   logic                  resv_valid_ff;
   logic [63:0]           resv_address_ff;
   amo_pkg::resv_upd_type resv_upd;
   logic                  rsp_advance;
   logic                  req_fire;
   logic                  req_take;

   assign req_in.cmd             = req_cmd;
   assign req_in.width_sel       = req_width_sel;
   assign req_in.address         = req_address;
   assign req_in.operand_value   = req_operand_value;
   assign req_in.memory_preimage = req_memory_preimage;
   assign req_in.access_ok       = req_access_ok;

   assign rsp_advance = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid_ff && rsp_advance;
   assign req_ready   = !req_valid_ff || rsp_advance;
   assign req_take    = req_valid && req_ready;

   amo_alu u_alu (
      .req          (req_ff),
      .xlen_is_64   (xlen_ff),
      .resv_valid   (resv_valid_ff),
      .resv_address (resv_address_ff),
      .rsp          (rsp_in),
      .resv_upd     (resv_upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         xlen_ff       <= 1'b1;
         resv_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (csr_write_enable) begin
            xlen_ff <= csr_write_data;
         end
         if (req_fire && resv_upd.set) begin
            resv_valid_ff <= 1'b1;
         end else if (req_fire && resv_upd.clear) begin
            resv_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resv_address_ff <= '0;
      end else if (req_fire && resv_upd.set) begin
         resv_address_ff <= resv_upd.address;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_illegal        = rsp_ff.illegal;
   assign rsp_mem_write      = rsp_ff.mem_write;
   assign rsp_mem_write_wide = rsp_ff.mem_write_wide;
   assign rsp_mem_write_data = rsp_ff.mem_write_data;
   assign rsp_rd_write       = rsp_ff.rd_write;
   assign rsp_rd_value       = rsp_ff.rd_value;

endmodule

// ===== hw/rtl/amo_checker.sv =====
// Port-level assertions for the atomic memory operation unit and their bind.
module amo_assertions (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_illegal,
   input logic        rsp_mem_write,
   input logic        rsp_mem_write_wide,
   input logic [63:0] rsp_mem_write_data,
   input logic        rsp_rd_write,
   input logic [63:0] rsp_rd_value
);

   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |-> !rsp_mem_write && !rsp_rd_write && rsp_rd_value == 64'd0)
      else $error("illegal response carries a write");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mem_write |-> !rsp_mem_write_wide && rsp_mem_write_data == 64'd0)
      else $error("memory write fields set without a write");

   a_word_zero_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write && !rsp_mem_write_wide |-> rsp_mem_write_data[63:32] == 32'd0)
      else $error("word store data not zero-extended");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rd_write |-> rsp_rd_value == 64'd0)
      else $error("rd value set without rd write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rd_value)
                                  && $stable(rsp_mem_write_data))
      else $error("stalled response changed");

endmodule

bind atomic_memory_op_unit_core amo_assertions u_amo_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_illegal        (rsp_illegal),
   .rsp_mem_write      (rsp_mem_write),
   .rsp_mem_write_wide (rsp_mem_write_wide),
   .rsp_mem_write_data (rsp_mem_write_data),
   .rsp_rd_write       (rsp_rd_write),
   .rsp_rd_value       (rsp_rd_value)
);

// ===== bench/amo_checker.sv =====
// Request/response checker for the atomic memory operation unit: predicts each response and compares it.
module amo_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [4:0]  req_cmd,
   input  logic [2:0]  req_width_sel,
   input  logic [63:0] req_address,
   input  logic [63:0] req_operand_value,
   input  logic [63:0] req_memory_preimage,
   input  logic        req_access_ok,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_illegal,
   input  logic        rsp_mem_write,
   input  logic        rsp_mem_write_wide,
   input  logic [63:0] rsp_mem_write_data,
   input  logic        rsp_rd_write,
   input  logic [63:0] rsp_rd_value,
   output int          error_count,
   output int          requests_in_flight
);

   amo_pkg::rsp_type pending_results[$];
   logic        xlen_64;
   logic        resv_valid;
   logic [63:0] resv_addr;

   function automatic logic [63:0] sext32(logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   function automatic amo_pkg::rsp_type predict_amo_result(amo_pkg::req_type r);
      amo_pkg::rsp_type res;
      logic        wide;
      logic [63:0] loaded;
      logic [63:0] b;
      logic [63:0] combined;
      res = '0;
      wide = (r.width_sel == amo_pkg::WIDTH_DOUBLE);
      if (wide && !xlen_64) begin
         res.illegal = 1'b1;
      end else if (r.access_ok) begin
         res.rd_write = 1'b1;
         if (r.cmd == amo_pkg::OP_SC) begin
            if (resv_valid && resv_addr == r.address) begin
               res.mem_write      = 1'b1;
               res.mem_write_wide = wide;
               res.mem_write_data = wide ? r.operand_value : {32'b0, r.operand_value[31:0]};
            end else begin
               res.rd_value = 64'd1;
            end
            resv_valid = 1'b0;
         end else begin
            loaded = wide ? r.memory_preimage : sext32(r.memory_preimage);
            res.rd_value = loaded;
            if (r.cmd == amo_pkg::OP_LR) begin
               resv_valid = 1'b1;
               resv_addr  = r.address;
            end else begin
               b = wide ? r.operand_value : sext32(r.operand_value);
               case (r.cmd)
                  amo_pkg::OP_SWAP: combined = b;
                  amo_pkg::OP_ADD:  combined = loaded + b;
                  amo_pkg::OP_XOR:  combined = loaded ^ b;
                  amo_pkg::OP_AND:  combined = loaded & b;
                  amo_pkg::OP_OR:   combined = loaded | b;
                  amo_pkg::OP_MIN:  combined = ($signed(loaded) < $signed(b)) ? loaded : b;
                  amo_pkg::OP_MAX:  combined = ($signed(b) < $signed(loaded)) ? loaded : b;
                  amo_pkg::OP_MINU: combined = (loaded < b) ? loaded : b;
                  amo_pkg::OP_MAXU: combined = (loaded > b) ? loaded : b;
                  default:          combined = loaded;
               endcase
               res.mem_write      = 1'b1;
               res.mem_write_wide = wide;
               res.mem_write_data = wide ? combined : {32'b0, combined[31:0]};
            end
         end
      end
      return res;
   endfunction

   function automatic int check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      amo_pkg::rsp_type want;
      amo_pkg::req_type r;
      int      errs;
      int      delta;
      errs  = 0;
      delta = 0;
      if (reset) begin
         pending_results.delete();
         xlen_64     = 1'b1;
         resv_valid  = 1'b0;
         resv_addr   = '0;
         error_count        <= 0;
         requests_in_flight <= 0;
      end else begin
         if (csr_write_enable) xlen_64 = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            delta = delta - 1;
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               errs = errs + 1;
            end else begin
               want = pending_results.pop_front();
               errs += check_field("illegal", 64'(want.illegal), 64'(rsp_illegal));
               errs += check_field("mem_write", 64'(want.mem_write), 64'(rsp_mem_write));
               errs += check_field("mem_write_wide", 64'(want.mem_write_wide),
                                   64'(rsp_mem_write_wide));
               errs += check_field("mem_write_data", want.mem_write_data, rsp_mem_write_data);
               errs += check_field("rd_write", 64'(want.rd_write), 64'(rsp_rd_write));
               errs += check_field("rd_value", want.rd_value, rsp_rd_value);
            end
         end
         if (req_valid && req_ready) begin
            delta = delta + 1;
            r = '{cmd: req_cmd, width_sel: req_width_sel, address: req_address,
                  operand_value: req_operand_value, memory_preimage: req_memory_preimage,
                  access_ok: req_access_ok};
            pending_results.push_back(predict_amo_result(r));
         end
         error_count        <= error_count + errs;
         requests_in_flight <= requests_in_flight + delta;
      end
   end

endmodule

// ===== bench/atomic_memory_op_unit_core_test.sv =====
// Testbench top for the atomic memory operation unit: clock, reset, stimulus and verdict.
module atomic_memory_op_unit_core_test;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_cmd = '0;
   logic [2:0]  req_width_sel = '0;
   logic [63:0] req_address = '0;
   logic [63:0] req_operand_value = '0;
   logic [63:0] req_memory_preimage = '0;
   logic        req_access_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_illegal;
   logic        rsp_mem_write;
   logic        rsp_mem_write_wide;
   logic [63:0] rsp_mem_write_data;
   logic        rsp_rd_write;
   logic [63:0] rsp_rd_value;

   int          error_count;
   int          requests_in_flight;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          issued_total = 0;
   logic [63:0] addr_pool[4];
   logic [4:0]  amo_ops[9] = '{amo_pkg::OP_SWAP, amo_pkg::OP_ADD, amo_pkg::OP_XOR,
                               amo_pkg::OP_AND, amo_pkg::OP_OR, amo_pkg::OP_MIN,
                               amo_pkg::OP_MAX, amo_pkg::OP_MINU, amo_pkg::OP_MAXU};

   atomic_memory_op_unit_core u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_width_sel       (req_width_sel),
      .req_address         (req_address),
      .req_operand_value   (req_operand_value),
      .req_memory_preimage (req_memory_preimage),
      .req_access_ok       (req_access_ok),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_illegal         (rsp_illegal),
      .rsp_mem_write       (rsp_mem_write),
      .rsp_mem_write_wide  (rsp_mem_write_wide),
      .rsp_mem_write_data  (rsp_mem_write_data),
      .rsp_rd_write        (rsp_rd_write),
      .rsp_rd_value        (rsp_rd_value)
   );

   amo_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_width_sel       (req_width_sel),
      .req_address         (req_address),
      .req_operand_value   (req_operand_value),
      .req_memory_preimage (req_memory_preimage),
      .req_access_ok       (req_access_ok),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_illegal         (rsp_illegal),
      .rsp_mem_write       (rsp_mem_write),
      .rsp_mem_write_wide  (rsp_mem_write_wide),
      .rsp_mem_write_data  (rsp_mem_write_data),
      .rsp_rd_write        (rsp_rd_write),
      .rsp_rd_value        (rsp_rd_value),
      .error_count         (error_count),
      .requests_in_flight  (requests_in_flight)
   );

   always #5 clock = ~clock;

   // stall the response channel on a rotating pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[9:8])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_ready <= (cycle_count[1:0] == 2'd0);
         default: rsp_ready <= cycle_count[3];
      endcase
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic amo_pkg::req_type mk_req(logic [4:0] cmd, logic [2:0] width,
                                               logic [63:0] addr, logic [63:0] rs2,
                                               logic [63:0] pre, logic ok);
      return '{cmd: cmd, width_sel: width, address: addr, operand_value: rs2,
               memory_preimage: pre, access_ok: ok};
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'h7fff_ffff_ffff_ffff;
         3:       return 64'h8000_0000_0000_0000;
         4:       return {$urandom, 32'h7fff_ffff};
         5:       return {$urandom, 32'h8000_0000};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_addr();
      if ($urandom_range(0, 1) == 0) return addr_pool[$urandom_range(0, 3)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [2:0] pick_width();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return amo_pkg::WIDTH_DOUBLE;
         4, 5, 6, 7: return 3'b010;
         default:    return 3'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic pick_ok();
      return $urandom_range(0, 9) != 0;
   endfunction

   function automatic amo_pkg::req_type random_amo();
      return mk_req(amo_ops[$urandom_range(0, 8)], pick_width(), pick_addr(),
                    pick_value(), pick_value(), pick_ok());
   endfunction

   // hold the request until accepted, then idle for a random gap, possibly none, between bursts
   task automatic send_request(input amo_pkg::req_type r);
      int gap;
      req_valid           <= 1'b1;
      req_cmd             <= r.cmd;
      req_width_sel       <= r.width_sel;
      req_address         <= r.address;
      req_operand_value   <= r.operand_value;
      req_memory_preimage <= r.memory_preimage;
      req_access_ok       <= r.access_ok;
      do @(posedge clock); while (!req_ready);
      issued_total++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (requests_in_flight != 0);
   endtask

   task automatic write_xlen(input logic v);
      drain_requests();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_sequence();
      logic [63:0] a;
      logic [2:0]  w;
      int          kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         a = pick_addr();
         w = pick_width();
         send_request(mk_req(amo_pkg::OP_LR, w, a, pick_value(), pick_value(), pick_ok()));
         repeat ($urandom_range(0, 2)) send_request(random_amo());
         send_request(mk_req(amo_pkg::OP_SC,
                             ($urandom_range(0, 4) == 0) ? pick_width() : w,
                             ($urandom_range(0, 4) == 0) ? pick_addr() : a,
                             pick_value(), pick_value(), pick_ok()));
      end else if (kind < 8) begin
         send_request(random_amo());
      end else begin
         send_request(mk_req(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, 1'($urandom_range(0, 1))));
      end
   endtask

   initial begin : stimulus
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      int          target;
      for (int i = 0; i < 4; i++) addr_pool[i] = {$urandom, $urandom};
      a = 64'hffff_ffff_ffff_fff8;
      b = 64'h0000_0000_0000_1000;
      c = 64'h0000_0000_0000_1004;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reservation behavior at reset width setting
      send_request(mk_req(amo_pkg::OP_LR, amo_pkg::WIDTH_DOUBLE, a, 64'd0,
                          64'h8000_0000_0000_0001, 1'b1));
      send_request(mk_req(amo_pkg::OP_SC, amo_pkg::WIDTH_DOUBLE, a, '1, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_SC, amo_pkg::WIDTH_DOUBLE, a, '1, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_LR, 3'b010, b, 64'd0, 64'h1234_5678_8000_0000, 1'b1));
      send_request(mk_req(amo_pkg::OP_SC, 3'b010, c, 64'h5, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_SC, 3'b010, b, 64'h5, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_LR, 3'b010, a, 64'd0, 64'h0000_0000_7fff_ffff, 1'b1));
      send_request(mk_req(amo_pkg::OP_LR, amo_pkg::WIDTH_DOUBLE, b, 64'd0, '1, 1'b0));
      send_request(mk_req(amo_pkg::OP_SC, 3'b010, a, 64'hdead_beef_cafe_f00d, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_SC, 3'b010, 64'd0, 64'd0, 64'd0, 1'b1));

      // every combine operation at the extremes
      send_request(mk_req(amo_pkg::OP_ADD, amo_pkg::WIDTH_DOUBLE, a, 64'd1, '1, 1'b1));
      send_request(mk_req(amo_pkg::OP_ADD, 3'b010, a, 64'd1, 64'hffff_ffff_7fff_ffff, 1'b1));
      send_request(mk_req(amo_pkg::OP_SWAP, 3'b000, b, '1, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_XOR, amo_pkg::WIDTH_DOUBLE, b,
                          64'haaaa_5555_aaaa_5555, '1, 1'b1));
      send_request(mk_req(amo_pkg::OP_AND, 3'b010, b, 64'h0000_0000_8000_ffff, '1, 1'b1));
      send_request(mk_req(amo_pkg::OP_OR, amo_pkg::WIDTH_DOUBLE, c,
                          64'h8000_0000_0000_0000, 64'd1, 1'b1));
      send_request(mk_req(amo_pkg::OP_MIN, amo_pkg::WIDTH_DOUBLE, c, 64'd1,
                          64'h8000_0000_0000_0000, 1'b1));
      send_request(mk_req(amo_pkg::OP_MAX, 3'b010, c, 64'h0000_0000_7fff_ffff,
                          64'h0000_0000_ffff_ffff, 1'b1));
      send_request(mk_req(amo_pkg::OP_MINU, 3'b010, c, 64'd1, 64'h0000_0000_ffff_ffff, 1'b1));
      send_request(mk_req(amo_pkg::OP_MAXU, amo_pkg::WIDTH_DOUBLE, c, '1, 64'd0, 1'b1));
      send_request(mk_req(5'd31, 3'b111, a, '1, 64'h0123_4567_89ab_cdef, 1'b1));
      send_request(mk_req(5'd5, amo_pkg::WIDTH_DOUBLE, a, 64'd0, 64'hfedc_ba98_7654_3210, 1'b1));

      // doubleword and word forms with the wide mode off
      write_xlen(1'b0);
      send_request(mk_req(amo_pkg::OP_ADD, amo_pkg::WIDTH_DOUBLE, a, 64'd1, 64'd1, 1'b0));
      send_request(mk_req(amo_pkg::OP_LR, amo_pkg::WIDTH_DOUBLE, b, 64'd0, 64'd7, 1'b1));
      send_request(mk_req(amo_pkg::OP_SC, 3'b010, b, 64'd9, 64'd0, 1'b1));
      send_request(mk_req(amo_pkg::OP_LR, 3'b010, c, 64'd0, 64'h0000_0000_8000_0000, 1'b1));
      send_request(mk_req(amo_pkg::OP_MAX, 3'b110, c, 64'h0000_0000_8000_0000,
                          64'h0000_0000_7fff_ffff, 1'b1));

      for (int p = 0; p < 8; p++) begin
         write_xlen((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
         target = issued_total + 200;
         while (issued_total < target) send_sequence();
      end

      drain_requests();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
